FILE: rtl/ps2ev_pkg.sv
// ----------------------------------------------------------------------------
// ps2ev_pkg
// Shared types and constants for the PS/2 input event decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2ev_pkg;

    // Event type codes
    localparam logic [1:0] EV_TYPE_KEY = 2'd1;
    localparam logic [1:0] EV_TYPE_REL = 2'd2;

    // Event code values
    localparam logic [8:0] CODE_AXIS_X     = 9'd0;
    localparam logic [8:0] CODE_AXIS_Y     = 9'd1;
    localparam logic [8:0] CODE_BTN_LEFT   = 9'd272;
    localparam logic [8:0] CODE_BTN_RIGHT  = 9'd273;
    localparam logic [8:0] CODE_BTN_MIDDLE = 9'd274;

    // Mouse byte phase within a packet
    localparam logic [1:0] PHASE_HEADER = 2'd0;
    localparam logic [1:0] PHASE_X      = 2'd1;
    localparam logic [1:0] PHASE_Y      = 2'd2;

    // Event mask bit positions, in emit order
    localparam int EVB_KEY   = 0;
    localparam int EVB_X     = 1;
    localparam int EVB_Y     = 2;
    localparam int EVB_LEFT  = 3;
    localparam int EVB_RIGHT = 4;
    localparam int EVB_MID   = 5;
    localparam int EV_BITS   = 6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int OUT_TDATA_W = 24;

    // One decoded job handed from front to back
    typedef struct packed {
        logic [EV_BITS-1:0] mask;     // events still to emit
        logic [7:0]         data;     // key byte or Y byte
        logic [7:0]         x_data;   // X byte
        logic [2:0]         buttons;  // new button state
    } job_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage : ps2ev_pkg

`default_nettype wire

FILE: rtl/ps2ev_front.sv
// ----------------------------------------------------------------------------
// ps2ev_front
// Accepts controller bytes, tracks the mouse packet and builds event jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2ev_front (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire  [7:0]               byte_value,
    input  wire                      from_aux,
    input  ps2ev_pkg::queue_status_t q_status,
    output logic                     push,
    output ps2ev_pkg::job_t          push_job
);
    import ps2ev_pkg::*;

    logic [1:0] phase_reg,   phase_next;
    logic [7:0] header_reg,  header_next;
    logic [7:0] x_reg,       x_next;
    logic [2:0] prev_btn_reg, prev_btn_next;

    logic       accept;
    logic [2:0] changed;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign changed  = header_reg[2:0] ^ prev_btn_reg;

    // Classify the beat and build the job
    always_comb
    begin
        phase_next    = phase_reg;
        header_next   = header_reg;
        x_next        = x_reg;
        prev_btn_next = prev_btn_reg;
        push_job      = '0;
        push_job.data    = byte_value;
        push_job.x_data  = x_reg;
        push_job.buttons = header_reg[2:0];
        if (!from_aux)
        begin
            push_job.mask[EVB_KEY] = 1'b1;
        end
        else if (phase_reg == PHASE_HEADER)
        begin
            header_next = byte_value;
            phase_next  = PHASE_X;
        end
        else if (phase_reg == PHASE_X)
        begin
            x_next     = byte_value;
            phase_next = PHASE_Y;
        end
        else
        begin
            push_job.mask[EVB_X]     = (x_reg != 8'd0);
            push_job.mask[EVB_Y]     = (byte_value != 8'd0);
            push_job.mask[EVB_LEFT]  = changed[0];
            push_job.mask[EVB_RIGHT] = changed[1];
            push_job.mask[EVB_MID]   = changed[2];
            prev_btn_next = header_reg[2:0];
            phase_next    = PHASE_HEADER;
        end
        push = accept && (push_job.mask != '0);
    end

    // Mouse packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_HEADER;
            header_reg   <= 8'd0;
            x_reg        <= 8'd0;
            prev_btn_reg <= 3'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            header_reg   <= header_next;
            x_reg        <= x_next;
            prev_btn_reg <= prev_btn_next;
        end
    end

endmodule : ps2ev_front

`default_nettype wire

FILE: rtl/ps2ev_queue.sv
// ----------------------------------------------------------------------------
// ps2ev_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2ev_queue (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  ps2ev_pkg::job_t          push_job,
    input  wire                      pop,
    output ps2ev_pkg::job_t          pop_job,
    output ps2ev_pkg::queue_status_t status
);
    import ps2ev_pkg::*;

    job_t                slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, wptr_next;
    logic [QUEUE_AW-1:0] rptr_reg, rptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign status.full  = (count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = slots_reg[rptr_reg];

    // Pointer and count update
    always_comb
    begin
        wptr_next  = wptr_reg + QUEUE_AW'(do_push);
        rptr_next  = rptr_reg + QUEUE_AW'(do_pop);
        count_next = count_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wptr_reg] <= push_job;
        end
    end

endmodule : ps2ev_queue

`default_nettype wire

FILE: rtl/ps2ev_back.sv
// ----------------------------------------------------------------------------
// ps2ev_back
// Expands queued jobs into events, one beat per cycle while the output is free, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2ev_back (
    input  wire                      clk,
    input  wire                      rst_n,
    input  ps2ev_pkg::queue_status_t q_status,
    input  ps2ev_pkg::job_t          pop_job,
    output logic                     pop,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [1:0]               event_type,
    output logic [8:0]               event_code,
    output logic signed [7:0]        event_value,
    output logic                     last_event
);
    import ps2ev_pkg::*;

    logic               cur_valid_reg, cur_valid_next;
    job_t               cur_reg,       cur_next;
    logic               ovalid_reg,    ovalid_next;
    logic [1:0]         type_reg,      type_next;
    logic [8:0]         code_reg,      code_next;
    logic [7:0]         value_reg,     value_next;
    logic               last_reg,      last_next;

    logic               out_free;
    logic               emit;
    logic [EV_BITS-1:0] pick;
    logic [EV_BITS-1:0] rest;

    assign out_free = !ovalid_reg || out_ready;
    assign emit     = cur_valid_reg && out_free;
    assign pick     = cur_reg.mask & (~cur_reg.mask + EV_BITS'(1));
    assign rest     = cur_reg.mask & ~pick;
    assign pop      = !q_status.empty && (!cur_valid_reg || (emit && rest == '0));

    // Current job tracking
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (emit)
        begin
            cur_next.mask = rest;
            if (rest == '0)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_next       = pop_job;
        end
    end

    // Event decode for the lowest pending bit
    always_comb
    begin
        ovalid_next = ovalid_reg;
        type_next   = type_reg;
        code_next   = code_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        if (out_free)
        begin
            ovalid_next = emit;
        end
        if (emit)
        begin
            last_next = (rest == '0);
            unique case (pick)
                EV_BITS'(1) << EVB_KEY:
                begin
                    type_next  = EV_TYPE_KEY;
                    code_next  = {2'b00, cur_reg.data[6:0]};
                    value_next = {7'd0, !cur_reg.data[7]};
                end
                EV_BITS'(1) << EVB_X:
                begin
                    type_next  = EV_TYPE_REL;
                    code_next  = CODE_AXIS_X;
                    value_next = cur_reg.x_data;
                end
                EV_BITS'(1) << EVB_Y:
                begin
                    type_next  = EV_TYPE_REL;
                    code_next  = CODE_AXIS_Y;
                    value_next = cur_reg.data;
                end
                EV_BITS'(1) << EVB_LEFT:
                begin
                    type_next  = EV_TYPE_KEY;
                    code_next  = CODE_BTN_LEFT;
                    value_next = {7'd0, cur_reg.buttons[0]};
                end
                EV_BITS'(1) << EVB_RIGHT:
                begin
                    type_next  = EV_TYPE_KEY;
                    code_next  = CODE_BTN_RIGHT;
                    value_next = {7'd0, cur_reg.buttons[1]};
                end
                default:
                begin
                    type_next  = EV_TYPE_KEY;
                    code_next  = CODE_BTN_MIDDLE;
                    value_next = {7'd0, cur_reg.buttons[2]};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        type_reg  <= type_next;
        code_reg  <= code_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign out_valid   = ovalid_reg;
    assign event_type  = type_reg;
    assign event_code  = code_reg;
    assign event_value = value_reg;
    assign last_event  = last_reg;

endmodule : ps2ev_back

`default_nettype wire

FILE: rtl/ps2_input_event_decoder.sv
// ----------------------------------------------------------------------------
// ps2_input_event_decoder
// Turns tagged PS/2 controller bytes into key, button and motion events.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per controller byte; tdata = byte_value, tuser = from_aux.
//   m_axis: one beat per event; tdata = type, code, value; tlast marks the
//   final event caused by one input byte.
//   A keyboard byte gives one event. A mouse packet's header and X bytes give
//   none; its third byte gives 0 to 5 events (X, Y, left, right, middle).
//   With the back part idle, an accepted byte's job passes through a queue
//   slot and the current-job register into the output register on m_axis.
//   Throughput: one event per cycle while m_tready is high, set by the single
//   event emitter; a byte is taken every cycle while the queue has room, and
//   a third packet byte holds the emitter for up to 5 events.
//   A 4-entry job queue lets the input side keep taking bytes while the
//   output stalls; s_tready drops only when the queue is full.
//   Reset clears the packet phase, the button history, the queue and the
//   output register; no beat is presented until a byte arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_input_event_decoder (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [7:0]                        s_tdata,   // [7:0] byte_value
    input  wire                               s_tuser,   // [0] from_aux
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [1:0] event_type, [10:2] event_code, [18:11] event_value, [23:19] zero
    output logic [ps2ev_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                              m_tlast    // last_event
);
    import ps2ev_pkg::*;

    queue_status_t     q_status;
    logic              push;
    job_t              push_job;
    logic              pop;
    job_t              pop_job;
    logic [1:0]        event_type;
    logic [8:0]        event_code;
    logic signed [7:0] event_value;

    ps2ev_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .byte_value (s_tdata),
        .from_aux   (s_tuser),
        .q_status   (q_status),
        .push       (push),
        .push_job   (push_job)
    );

    ps2ev_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    ps2ev_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .pop_job     (pop_job),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .last_event  (m_tlast)
    );

    // Pack the output beat
    assign m_tdata = {5'd0, event_value, event_code, event_type};

endmodule : ps2_input_event_decoder

`default_nettype wire
